// ===== rtl/keypad_alarm_controller_defines.svh =====
// assertion macros for the keypad alarm controller
// expects clk_i and rst_ni in the scope of every use
`ifndef KEYPAD_ALARM_CONTROLLER_DEFINES_SVH
`define KEYPAD_ALARM_CONTROLLER_DEFINES_SVH

// plain invariant, checked at every edge out of reset
`define KAC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication
`define KAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kac_pkg.sv =====
// types and constants shared by the keypad alarm controller modules
// no dependencies
package kac_pkg;

  localparam int KeyW   = 4;
  localparam int SecsW  = 8;
  localparam int LimitW = 4;
  localparam int FailW  = 4;
  localparam int CfgW   = 8;
  localparam int CfgIdxW = 1;

  localparam logic [SecsW-1:0]  DelayResetVal = 8'd11;
  localparam logic [LimitW-1:0] LimitResetVal = 4'd3;
  localparam logic [FailW-1:0]  FailMax       = 4'd15;

  typedef enum logic [2:0] {
    EvNone       = 3'd0,
    EvCodeSet    = 3'd1,
    EvDisarmed   = 3'd2,
    EvCountStart = 3'd3,
    EvWrong      = 3'd4,
    EvAlarm      = 3'd5,
    EvArmed      = 3'd6
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegDelay = 1'b0,
    RegLimit = 1'b1
  } cfg_reg_e;

  // one input beat
  typedef struct packed {
    logic            kind;
    logic            key_valid;
    logic [KeyW-1:0] key_code;
    logic            sensor_high;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic             armed;
    logic             alarm_on;
    logic             counting;
    logic [SecsW-1:0] seconds_left;
    logic             code_setup;
    logic [FailW-1:0] failed_count;
    event_e           event_res;
  } res_t;

endpackage

// ===== rtl/kac_in_reg.sv =====
// input register stage of the keypad alarm controller
// depends on kac_pkg
module kac_in_reg
  import kac_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  output logic     valid_o,
  input  logic     take_i,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/kac_core.sv =====
// panel state and single-pass update logic of the keypad alarm controller
// depends on kac_pkg and keypad_alarm_controller_defines.svh
`include "keypad_alarm_controller_defines.svh"

module kac_core
  import kac_pkg::*;
#(
  parameter int CODE_LEN = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  in_item_t           item_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output res_t               res_o
);

  localparam int PosW = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam logic [PosW:0]   PosLimit = (PosW + 1)'(CODE_LEN);
  localparam logic [PosW-1:0] PosLast  = PosW'(CODE_LEN - 1);

  logic [KeyW-1:0] code_q  [CODE_LEN];
  logic [KeyW-1:0] entry_q [CODE_LEN];

  logic [PosW-1:0]   pos_q, pos_d;
  logic              setup_q, setup_d;
  logic              armed_q, armed_d;
  logic              alarm_q, alarm_d;
  logic              trip_q, trip_d;
  logic              count_q, count_d;
  logic [SecsW-1:0]  secs_q, secs_d;
  logic [FailW-1:0]  fail_q, fail_d;
  logic [SecsW-1:0]  delay_q, delay_d;
  logic [LimitW-1:0] limit_q, limit_d;

  logic [PosW-1:0]  pos_eff;
  logic             pos_end;
  logic             match;
  logic             code_we, entry_we;
  logic [SecsW-1:0] secs_dec;
  logic             trip;
  event_e           ev;

  // current entry with the incoming key merged in
  always_comb begin
    pos_eff = ({1'b0, pos_q} >= PosLimit) ? '0 : pos_q;
    pos_end = (pos_eff == PosLast);
    match   = 1'b1;
    for (int i = 0; i < CODE_LEN; i++) begin
      if (PosW'(i) == pos_eff) begin
        if (item_i.key_code != code_q[i]) match = 1'b0;
      end else begin
        if (entry_q[i] != code_q[i]) match = 1'b0;
      end
    end
  end

  always_comb begin
    pos_d    = pos_q;
    setup_d  = setup_q;
    armed_d  = armed_q;
    alarm_d  = alarm_q;
    count_d  = count_q;
    secs_d   = secs_q;
    fail_d   = fail_q;
    trip     = trip_q;
    ev       = EvNone;
    code_we  = 1'b0;
    entry_we = 1'b0;
    secs_dec = secs_q - 8'd1;

    if (step_i) begin
      if (item_i.kind) begin
        // one-second tick
        if (count_q) begin
          secs_d = secs_dec;
          if (secs_dec == '0) begin
            if (trip_q) begin
              alarm_d = 1'b1;
              ev      = EvAlarm;
            end else if (!armed_q) begin
              armed_d = 1'b1;
              ev      = EvArmed;
            end
            count_d = 1'b0;
            secs_d  = delay_q;
          end
        end
      end else begin
        // poll
        if (item_i.sensor_high) trip = 1'b1;
        if (item_i.key_valid) begin
          pos_d = pos_end ? '0 : pos_eff + 1'b1;
          if (setup_q) begin
            code_we = 1'b1;
            if (pos_end) begin
              setup_d = 1'b0;
              ev      = EvCodeSet;
            end
          end else begin
            entry_we = 1'b1;
            if (pos_end) begin
              if (match) begin
                if (alarm_q || trip) begin
                  alarm_d = 1'b0;
                  armed_d = 1'b0;
                  trip    = 1'b0;
                  count_d = 1'b0;
                  secs_d  = delay_q;
                  ev      = EvDisarmed;
                end else begin
                  count_d = 1'b1;
                  ev      = EvCountStart;
                end
                fail_d = '0;
              end else begin
                fail_d = (fail_q == FailMax) ? fail_q : fail_q + 1'b1;
                ev     = EvWrong;
              end
            end
            // too many wrong entries while tripped
            if (limit_q != '0 && fail_d == limit_q && !alarm_d && trip) begin
              fail_d  = '0;
              alarm_d = 1'b1;
              count_d = 1'b0;
              ev      = EvAlarm;
            end
          end
        end
        // pending trip: entry delay when armed, dropped when not armed
        if (trip) begin
          if (armed_d && !alarm_d) begin
            if (!count_d && ev == EvNone) ev = EvCountStart;
            count_d = 1'b1;
          end else if (!armed_d) begin
            trip = 1'b0;
          end
        end
      end
    end else if (cfg_we_i && cfg_reg_e'(cfg_idx_i) == RegDelay && !count_q) begin
      secs_d = cfg_data_i;
    end
    trip_d = trip;
  end

  always_comb begin
    delay_d = delay_q;
    limit_d = limit_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegDelay: delay_d = cfg_data_i;
        RegLimit: limit_d = cfg_data_i[LimitW-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      setup_q <= 1'b1;
      armed_q <= 1'b0;
      alarm_q <= 1'b0;
      trip_q  <= 1'b0;
      count_q <= 1'b0;
      secs_q  <= DelayResetVal;
      fail_q  <= '0;
      delay_q <= DelayResetVal;
      limit_q <= LimitResetVal;
    end else begin
      pos_q   <= pos_d;
      setup_q <= setup_d;
      armed_q <= armed_d;
      alarm_q <= alarm_d;
      trip_q  <= trip_d;
      count_q <= count_d;
      secs_q  <= secs_d;
      fail_q  <= fail_d;
      delay_q <= delay_d;
      limit_q <= limit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CODE_LEN; i++) begin
      if (code_we && pos_eff == PosW'(i)) code_q[i] <= item_i.key_code;
      if (entry_we && pos_eff == PosW'(i)) entry_q[i] <= item_i.key_code;
    end
  end

  assign res_o = '{
    armed:        armed_d,
    alarm_on:     alarm_d,
    counting:     count_d,
    seconds_left: secs_d,
    code_setup:   setup_d,
    failed_count: fail_d,
    event_res:    ev
  };

  `KAC_ASSERT(a_alarm_stops_count, !(alarm_q && count_q), "alarm with countdown running")
  `KAC_ASSERT_IMP(a_setup_quiet, setup_q, !armed_q && !alarm_q && fail_q == '0,
                  "panel active during code setup")
  `KAC_ASSERT_NEXT(a_armed_event, step_i && ev == EvArmed, armed_q,
                   "armed event without armed state")
  `KAC_ASSERT_NEXT(a_disarm_event, step_i && ev == EvDisarmed,
                   !armed_q && !alarm_q && !trip_q && !count_q,
                   "disarm left state set")

endmodule

// ===== rtl/kac_out_reg.sv =====
// result register stage of the keypad alarm controller
// depends on kac_pkg
module kac_out_reg
  import kac_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  output logic free_o,
  input  res_t res_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/keypad_alarm_controller.sv =====
// top level of the keypad alarm controller: stream ports, beat packing
// depends on kac_pkg, kac_in_reg, kac_core and kac_out_reg
//
// security panel controller. every input beat is either a poll (sensor level
// plus an optional key) or a one-second tick, and every input beat gives
// exactly one result beat with the panel state after it and an event code.
// the first CODE_LEN keys after reset store the access code; later groups of
// CODE_LEN keys disarm, start the exit countdown or count a wrong entry. one
// beat can be taken every clock cycle while the result side is not stalled; a
// beat sits in the input register until the output register is free and is
// then applied to the panel state in a single pass, its result landing in the
// output register at the next edge, from where it is offered. only a stalled
// result side holds the input back: s_axis_tready drops when both registers
// hold a beat and m_axis_tready is low. configuration writes (countdown length,
// attempt limit) take effect at the next edge and must be made with the block
// idle; a new countdown length also reloads the second counter when no countdown
// is running.
module keypad_alarm_controller
  import kac_pkg::*;
#(
  parameter int CODE_LEN = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // key_valid, key_code[3:0], sensor_high, zero pad
  input  logic               s_axis_tuser,  // kind (0 poll, 1 tick)
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // armed, alarm_on, counting, seconds_left[7:0], code_setup, failed_count[3:0],
  // event_res[2:0], zero pad
  output logic [23:0]        m_axis_tdata,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  in_item_t in_item, cur_item;
  logic     cur_valid;
  logic     out_free;
  logic     step;
  res_t     next_res, out_res;

  // unpack the input beat
  assign in_item = '{
    kind:        s_axis_tuser,
    key_valid:   s_axis_tdata[0],
    key_code:    s_axis_tdata[4:1],
    sensor_high: s_axis_tdata[5]
  };

  // a held beat is applied whenever the result register can take its result
  assign step = cur_valid && out_free;

  kac_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (cur_valid),
    .take_i  (step),
    .item_o  (cur_item)
  );

  kac_core #(
    .CODE_LEN (CODE_LEN)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (cur_item),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (next_res)
  );

  kac_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .free_o  (out_free),
    .res_i   (next_res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  // pack the result beat, first field in the lowest bit
  assign m_axis_tdata = {
    5'b0,
    out_res.event_res,
    out_res.failed_count,
    out_res.code_setup,
    out_res.seconds_left,
    out_res.counting,
    out_res.alarm_on,
    out_res.armed
  };

endmodule

// ===== verif/keypad_alarm_controller_tb.sv =====
// self-checking testbench for the keypad alarm controller: stream stimulus, result checks
// depends on kac_pkg and keypad_alarm_controller; a small class mirrors the panel state
module keypad_alarm_controller_tb;
  import kac_pkg::*;

  localparam int CODE_LEN    = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 400;  // results seen before the long receiver hold-off
  localparam int HOLD_LEN    = 300;

  // mirror of the panel: takes each accepted beat, queues the state it should report
  class alarm_panel_scoreboard;
    logic [SecsW-1:0]  delay_len;
    logic [LimitW-1:0] fail_limit;
    logic [KeyW-1:0]   access_code[CODE_LEN];
    logic [KeyW-1:0]   entry[CODE_LEN];
    int unsigned       pos;
    bit                setup, armed, alarm, tripped, counting;
    logic [SecsW-1:0]  secs;
    logic [FailW-1:0]  wrong_count;
    res_t              expected_states[$];
    int unsigned       bad_results;
    int unsigned       checked;

    function new();
      delay_len   = DelayResetVal;
      fail_limit  = LimitResetVal;
      pos         = 0;
      setup       = 1'b1;
      armed       = 1'b0;
      alarm       = 1'b0;
      tripped     = 1'b0;
      counting    = 1'b0;
      secs        = DelayResetVal;
      wrong_count = '0;
      bad_results = 0;
      checked     = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgW-1:0] val);
      if (idx == RegDelay) begin
        delay_len = val;
        if (!counting) secs = delay_len;
      end else begin
        fail_limit = val[LimitW-1:0];
      end
    endfunction

    function event_e take_key(logic [KeyW-1:0] key);
      event_e      ev;
      int unsigned p;
      bit          same;
      ev = EvNone;
      p  = (pos >= CODE_LEN) ? 0 : pos;
      // code setup: keys just fill the stored code
      if (setup) begin
        access_code[p] = key;
        p++;
        if (p == CODE_LEN) begin
          p     = 0;
          setup = 1'b0;
          ev    = EvCodeSet;
        end
        pos = p;
        return ev;
      end
      entry[p] = key;
      p++;
      if (p == CODE_LEN) begin
        p    = 0;
        same = 1'b1;
        for (int i = 0; i < CODE_LEN; i++)
          if (entry[i] != access_code[i]) same = 1'b0;
        if (same) begin
          if (alarm || tripped) begin
            alarm    = 1'b0;
            armed    = 1'b0;
            tripped  = 1'b0;
            counting = 1'b0;
            secs     = delay_len;
            ev       = EvDisarmed;
          end else begin
            counting = 1'b1;
            ev       = EvCountStart;
          end
          wrong_count = '0;
        end else begin
          if (wrong_count != FailMax) wrong_count++;
          ev = EvWrong;
        end
      end
      pos = p;
      // too many wrong entries with a trip pending raises the alarm
      if (fail_limit != 0 && wrong_count == fail_limit && !alarm && tripped) begin
        wrong_count = '0;
        alarm       = 1'b1;
        counting    = 1'b0;
        ev          = EvAlarm;
      end
      return ev;
    endfunction

    function event_e tick_second();
      event_e ev;
      ev = EvNone;
      if (!counting) return ev;
      secs--;
      if (secs == 0) begin
        if (tripped) begin
          alarm = 1'b1;
          ev    = EvAlarm;
        end else if (!armed) begin
          armed = 1'b1;
          ev    = EvArmed;
        end
        counting = 1'b0;
        secs     = delay_len;
      end
      return ev;
    endfunction

    function void note_input(in_item_t it);
      event_e ev;
      res_t   r;
      ev = EvNone;
      if (it.kind) begin
        ev = tick_second();
      end else begin
        if (it.sensor_high) tripped = 1'b1;
        if (it.key_valid) ev = take_key(it.key_code);
        if (tripped) begin
          if (armed && !alarm) begin
            if (!counting && ev == EvNone) ev = EvCountStart;
            counting = 1'b1;
          end else if (!armed) begin
            tripped = 1'b0;
          end
        end
      end
      r.armed        = armed;
      r.alarm_on     = alarm;
      r.counting     = counting;
      r.seconds_left = secs;
      r.code_setup   = setup;
      r.failed_count = wrong_count;
      r.event_res    = ev;
      expected_states.push_back(r);
    endfunction

    function string show(res_t r);
      return $sformatf("armed=%0b alarm=%0b counting=%0b secs=%0d setup=%0b fails=%0d ev=%0d",
                       r.armed, r.alarm_on, r.counting, r.seconds_left, r.code_setup,
                       r.failed_count, r.event_res);
    endfunction

    function void check_result(logic [23:0] d);
      res_t got, want;
      got.armed        = d[0];
      got.alarm_on     = d[1];
      got.counting     = d[2];
      got.seconds_left = d[10:3];
      got.code_setup   = d[11];
      got.failed_count = d[15:12];
      got.event_res    = event_e'(d[18:16]);
      if (expected_states.size() == 0) begin
        if (bad_results < 10) $display("unexpected result beat: %s", show(got));
        bad_results++;
        return;
      end
      want = expected_states.pop_front();
      if (got !== want) begin
        if (bad_results < 10) begin
          $display("result %0d mismatch", checked);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
        bad_results++;
      end
      checked++;
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = '0;   // key_valid, key_code[3:0], sensor_high, zero pad
  logic               s_axis_tuser  = 1'b0; // kind (0 poll, 1 tick)
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [23:0]        m_axis_tdata;         // armed, alarm_on, counting, seconds_left[7:0],
                                            // code_setup, failed_count[3:0], event_res[2:0]
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [CfgW-1:0]    cfg_data_i    = '0;

  alarm_panel_scoreboard sb = new();

  int unsigned burst_left    = 0;  // beats left in the current sender burst
  int unsigned sent_items    = 0;  // input beats accepted so far
  int unsigned results_seen  = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  int unsigned stall_tick    = 0;

  keypad_alarm_controller #(.CODE_LEN(CODE_LEN)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // result side: check every accepted beat, then pick tready for the next edge.
  // the stall pattern rotates through always ready, mostly ready, mostly stalled
  // and alternating; once, after HOLD_AT results, tready stays low for a
  // long stretch so the block backs up into its input
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
      results_seen++;
    end
    stall_tick++;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      case ((stall_tick / 50) % 4)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= stall_tick[0];
      endcase
    end
  end

  // one input beat, with the sender idling in bursts and gaps
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {2'b00, it.sensor_high, it.key_code, it.key_valid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
    sb.note_input(it);
  endtask

  task automatic poll(input logic kv, input logic [KeyW-1:0] key, input logic sensor);
    in_item_t it;
    it.kind        = 1'b0;
    it.key_valid   = kv;
    it.key_code    = key;
    it.sensor_high = sensor;
    send_item(it);
  endtask

  // key fields ride along on ticks with random junk, they must be ignored
  task automatic tick_beat();
    in_item_t it;
    it.kind        = 1'b1;
    it.key_valid   = 1'($urandom_range(0, 1));
    it.key_code    = 4'($urandom_range(0, 15));
    it.sensor_high = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // four keys, digit 0 in the low nibble; mess adds stray trips and empty polls
  task automatic enter_group(input logic [15:0] digits, input bit mess);
    for (int k = 0; k < CODE_LEN; k++) begin
      if (mess && $urandom_range(0, 7) == 0) poll(1'b0, 4'($urandom_range(0, 15)), 1'b0);
      poll(1'b1, digits[k*4 +: 4], mess && ($urandom_range(0, 7) == 0));
    end
  endtask

  // a whole entry, realigned to a group boundary first
  task automatic enter_code(input bit right);
    logic [15:0] digits;
    int unsigned k;
    while (sb.pos != 0) poll(1'b1, 4'($urandom_range(0, 15)), 1'b0);
    for (k = 0; k < CODE_LEN; k++) digits[k*4 +: 4] = sb.access_code[k];
    if (!right) begin
      if ($urandom_range(0, 2) == 0) begin
        digits = 16'($urandom);
      end else begin
        k = $urandom_range(0, CODE_LEN - 1);
        digits[k*4 +: 4] ^= 4'($urandom_range(1, 15));
      end
    end
    enter_group(digits, 1'b1);
  endtask

  task automatic random_scenario();
    int unsigned pick, n;
    in_item_t    it;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      enter_code(1'b1);
    end else if (pick < 55) begin
      enter_code(1'b0);
    end else if (pick < 75) begin
      // run the countdown down, sometimes past its end
      n = sb.counting ? $urandom_range(1, sb.secs + 2) : $urandom_range(1, 2);
      repeat (n) tick_beat();
    end else if (pick < 85) begin
      poll(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 1'b1);
    end else if (pick < 93) begin
      // broken entry: a few keys, then something else
      n = $urandom_range(1, CODE_LEN - 1);
      repeat (n) poll(1'b1, 4'($urandom_range(0, 15)), $urandom_range(0, 7) == 0);
    end else if (pick < 96) begin
      // long run of wrong entries, drives the failure count into saturation
      n = $urandom_range(15, 18);
      repeat (n) enter_code(1'b0);
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        it.kind        = 1'($urandom_range(0, 1));
        it.key_valid   = 1'($urandom_range(0, 1));
        it.key_code    = 4'($urandom_range(0, 15));
        it.sensor_high = 1'($urandom_range(0, 1));
        send_item(it);
      end
    end
  endtask

  // sender stops and waits for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.expected_states.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [CfgW-1:0] delay_val, input logic [LimitW-1:0] limit);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegDelay;
    cfg_data_i <= delay_val;
    @(posedge clk_i);
    sb.write_reg(RegDelay, delay_val);
    cfg_idx_i  <= RegLimit;
    cfg_data_i <= CfgW'(limit);
    @(posedge clk_i);
    sb.write_reg(RegLimit, CfgW'(limit));
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CfgW-1:0] delay_val, input logic [LimitW-1:0] limit,
                           input int unsigned n);
    int unsigned target;
    drain();
    write_regs(delay_val, limit);
    target = sent_items + n;
    while (sent_items < target) random_scenario();
  endtask

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL keypad_alarm_controller");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty poll with junk key fields, idle tick, then code setup
    // with trips that an unarmed panel drops
    poll(1'b0, 4'hA, 1'b0);
    tick_beat();
    poll(1'b1, 4'd15, 1'b1);
    poll(1'b1, 4'd0, 1'b0);
    poll(1'b1, 4'd9, 1'b0);
    poll(1'b1, 4'd6, 1'b1);
    drain();

    // short countdown, single attempt: wrong, arm, trip, alarm on a wrong entry, disarm
    write_regs(8'd2, 4'd1);
    enter_group(16'h7_9_0_F, 1'b0);
    enter_group(16'h6_9_0_F, 1'b0);
    tick_beat();
    tick_beat();
    poll(1'b0, 4'h5, 1'b1);
    enter_group(16'h3_3_3_3, 1'b0);
    enter_group(16'h6_9_0_F, 1'b0);

    run_phase(8'd1, 4'd1, 250);
    run_phase(8'd255, 4'd15, 300);
    run_phase(8'd3, 4'd2, 300);
    run_phase(8'd2, 4'd3, 250);
    run_phase(8'($urandom_range(1, 20)), 4'($urandom_range(1, 15)), 250);

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.bad_results == 0 && sb.expected_states.size() == 0)
      $display("PASS keypad_alarm_controller");
    else
      $display("FAIL keypad_alarm_controller");
    $finish;
  end

endmodule
